[rtl/core/periodic_task_tick_scheduler_assert.svh]
// Assertion macros shared by the scheduler RTL.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PTS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/pts_pkg.sv]
package pts_pkg;

    localparam int MAX_TASKS  = 8;
    localparam int SLOT_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int OUT_MAX    = 8;
    localparam int FCNT_W     = $clog2(OUT_MAX + 1);
    localparam int IDX_W      = 3;
    localparam int CNT_W      = 16;

    typedef enum logic [2:0] {
        REQ_TICK    = 3'd0,
        REQ_CREATE  = 3'd1,
        REQ_DELETE  = 3'd2,
        REQ_SUSPEND = 3'd3,
        REQ_QUERY   = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ST_DORMANT   = 2'd0,
        ST_READY     = 2'd1,
        ST_SUSPENDED = 2'd2
    } slot_state_t;

    typedef enum logic [2:0] {
        TOP_NOP     = 3'd0,
        TOP_CREATE  = 3'd1,
        TOP_DELETE  = 3'd2,
        TOP_SUSPEND = 3'd3,
        TOP_STEP    = 3'd4
    } tbl_op_t;

    typedef struct packed {
        tbl_op_t             op;
        logic [SLOT_W-1:0]   addr;
        logic [CNT_W-1:0]    period;
        logic [CNT_W-1:0]    delay;
        logic                handler;
    } tbl_cmd_t;

    typedef struct packed {
        logic [1:0] state;
        logic       participate;
        logic       fire;
    } tbl_view_t;

    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        return SLOT_W'(idx);
    endfunction

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return (32'(idx) < 32'(MAX_TASKS));
    endfunction

endpackage

[rtl/core/periodic_task_tick_scheduler.sv]
// Channel   Dir  Ports                                   Meaning
// s_        in   s_tvalid s_tready s_tdata[39:0]         one request beat
//                s_tuser[2:0]
// m_        out  m_tvalid m_tready m_tdata[7:0] m_tlast  one result beat
//
// A request beat is taken only while the sequencer is idle. A tick walks the
// slot table one slot per cycle, except while the scan waits to hand an older
// firing to a busy output. Create, delete and suspend pass through the write
// state, and a query answer waits on output back-pressure.
// Reset is synchronous on aresetn low and clears the slot table at once.
// A stalled result beat holds in the output register while the scan waits.

`include "periodic_task_tick_scheduler_assert.svh"

module periodic_task_tick_scheduler
    import pts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: slot_index[2:0], period_ticks[18:3],
    // first_delay[34:19], handler_present[35], zero fill [39:36]
    input  logic [39:0] s_tdata,
    // s_tuser: req_type[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata from bit 0: fired_slot[2:0], fired[3], slot_state[5:4],
    // zero fill [7:6]
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    // The sequencer: idle, apply a table write, answer a query, scan the
    // slots for a tick, and finally deliver the held last result of a tick.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WRITE = 5'b00010,
        S_QUERY = 5'b00100,
        S_SCAN  = 5'b01000,
        S_FLUSH = 5'b10000
    } seq_state_t;

    seq_state_t        state_reg, state_next;

    // Latched request.
    req_t              req_reg, req_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  per_reg, per_next;
    logic [CNT_W-1:0]  dly_reg, dly_next;
    logic              hnd_reg, hnd_next;
    logic              rng_reg, rng_next;

    // Tick scan bookkeeping. A firing is held back in the pending register
    // until the next firing or the end of the scan shows whether it is last.
    logic [SLOT_W-1:0] scan_reg, scan_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [2:0]        pend_slot_reg, pend_slot_next;
    logic [FCNT_W-1:0] fcnt_reg, fcnt_next;

    // Output register.
    logic              m_tvalid_reg, m_tvalid_next;
    logic [2:0]        out_slot_reg, out_slot_next;
    logic              out_fired_reg, out_fired_next;
    logic [1:0]        out_state_reg, out_state_next;
    logic              m_tlast_reg, m_tlast_next;

    tbl_cmd_t          cmd;
    tbl_view_t         view;

    logic              s_accept;
    logic              out_free;
    logic              take_fire;

    pts_slot_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .view    (view)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_state_reg, out_fired_reg, out_slot_reg};
    assign m_tlast  = m_tlast_reg;

    // A firing is reported only while fewer than OUT_MAX have been recorded.
    assign take_fire = view.fire && (fcnt_reg < FCNT_W'(OUT_MAX));

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        per_next        = per_reg;
        dly_next        = dly_reg;
        hnd_next        = hnd_reg;
        rng_next        = rng_reg;
        scan_next       = scan_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        fcnt_next       = fcnt_reg;

        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_slot_next   = out_slot_reg;
        out_fired_next  = out_fired_reg;
        out_state_next  = out_state_reg;
        m_tlast_next    = m_tlast_reg;

        cmd.op          = TOP_NOP;
        cmd.addr        = to_slot(idx_reg);
        cmd.period      = per_reg;
        cmd.delay       = dly_reg;
        cmd.handler     = hnd_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    req_next        = req_t'(s_tuser);
                    idx_next        = s_tdata[2:0];
                    per_next        = s_tdata[18:3];
                    dly_next        = s_tdata[34:19];
                    hnd_next        = s_tdata[35];
                    rng_next        = in_range(s_tdata[2:0]);
                    scan_next       = '0;
                    pend_valid_next = 1'b0;
                    fcnt_next       = '0;
                    case (req_t'(s_tuser))
                        REQ_TICK:    state_next = S_SCAN;
                        REQ_CREATE:  state_next = S_WRITE;
                        REQ_DELETE:  state_next = S_WRITE;
                        REQ_SUSPEND: state_next = S_WRITE;
                        REQ_QUERY:   state_next = S_QUERY;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_WRITE: begin
                if (rng_reg) begin
                    case (req_reg)
                        REQ_CREATE:  cmd.op = TOP_CREATE;
                        REQ_DELETE:  cmd.op = TOP_DELETE;
                        REQ_SUSPEND: cmd.op = TOP_SUSPEND;
                        default:     cmd.op = TOP_NOP;
                    endcase
                end
                state_next = S_IDLE;
            end
            S_QUERY: begin
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    out_slot_next  = '0;
                    out_fired_next = 1'b0;
                    out_state_next = rng_reg ? view.state : ST_DORMANT;
                    m_tlast_next   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SCAN: begin
                cmd.addr = scan_reg;
                // Wait when an older firing must go out and the output is busy.
                if (!(take_fire && pend_valid_reg && !out_free)) begin
                    cmd.op = TOP_STEP;
                    if (take_fire) begin
                        if (pend_valid_reg) begin
                            m_tvalid_next  = 1'b1;
                            out_slot_next  = pend_slot_reg;
                            out_fired_next = 1'b1;
                            out_state_next = ST_DORMANT;
                            m_tlast_next   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = 3'(scan_reg);
                        fcnt_next       = fcnt_reg + FCNT_W'(1);
                    end
                    if (scan_reg == SLOT_W'(MAX_TASKS - 1)) begin
                        state_next = S_FLUSH;
                    end else begin
                        scan_next = scan_reg + SLOT_W'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    out_slot_next  = pend_valid_reg ? pend_slot_reg : 3'd0;
                    out_fired_next = pend_valid_reg;
                    out_state_next = ST_DORMANT;
                    m_tlast_next   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            fcnt_reg       <= '0;
            scan_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            fcnt_reg       <= fcnt_next;
            scan_reg       <= scan_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        idx_reg       <= idx_next;
        per_reg       <= per_next;
        dly_reg       <= dly_next;
        hnd_reg       <= hnd_next;
        rng_reg       <= rng_next;
        pend_slot_reg <= pend_slot_next;
        out_slot_reg  <= out_slot_next;
        out_fired_reg <= out_fired_next;
        out_state_reg <= out_state_next;
        m_tlast_reg   <= m_tlast_next;
    end

    // An empty tick result or a query answer is always the last beat.
    `PTS_ASSERT_SAME(a_unfired_is_last, m_tvalid && !m_tdata[3], m_tlast, "unfired beat without tlast")
    // The count of reported firings never passes the result room.
    `PTS_ASSERT_SAME(a_fcnt_bound, 1'b1, fcnt_reg <= FCNT_W'(OUT_MAX), "firing count overflow")
    // An accepted tick starts a fresh scan with nothing pending.
    `PTS_ASSERT_NEXT(a_tick_starts_scan, s_accept && s_tuser == REQ_TICK, state_reg == S_SCAN && !pend_valid_reg && scan_reg == '0, "tick did not start a clean scan")

endmodule

[rtl/core/pts_slot_table.sv]
module pts_slot_table
    import pts_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  tbl_cmd_t  cmd,
    output tbl_view_t view
);

    logic [CNT_W-1:0] period_reg [MAX_TASKS];
    logic [CNT_W-1:0] cd_reg     [MAX_TASKS];
    logic             hnd_reg    [MAX_TASKS];
    logic [1:0]       st_reg     [MAX_TASKS];

    logic [CNT_W-1:0] cur_period;
    logic [CNT_W-1:0] cur_cd;
    logic [CNT_W-1:0] operand;
    logic [CNT_W-1:0] cd_next;

    // One shared decrementer serves both the reload (period - 1) and the
    // ordinary countdown step.
    always_comb begin
        cur_period       = period_reg[cmd.addr];
        cur_cd           = cd_reg[cmd.addr];
        view.state       = st_reg[cmd.addr];
        view.participate = (st_reg[cmd.addr] == ST_READY) && hnd_reg[cmd.addr];
        view.fire        = view.participate && (cur_cd == '0);
        operand          = view.fire ? cur_period : cur_cd;
        cd_next          = operand - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
                period_reg[i] <= '0;
                cd_reg[i]     <= '0;
                hnd_reg[i]    <= 1'b0;
                st_reg[i]     <= ST_DORMANT;
            end
        end else begin
            case (cmd.op)
                TOP_CREATE: begin
                    period_reg[cmd.addr] <= cmd.period;
                    cd_reg[cmd.addr]     <= cmd.delay;
                    hnd_reg[cmd.addr]    <= cmd.handler;
                    st_reg[cmd.addr]     <= ST_READY;
                end
                TOP_DELETE: begin
                    period_reg[cmd.addr] <= '0;
                    cd_reg[cmd.addr]     <= '0;
                    hnd_reg[cmd.addr]    <= 1'b0;
                    st_reg[cmd.addr]     <= ST_DORMANT;
                end
                TOP_SUSPEND: begin
                    st_reg[cmd.addr] <= ST_SUSPENDED;
                end
                TOP_STEP: begin
                    if (view.participate) begin
                        cd_reg[cmd.addr] <= cd_next;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
